// File: rtl/s2c_pkg.sv
`timescale 1ns / 1ps

package s2c_pkg;

	// Seconds per day is 675 * 128; the low seven bits bypass the divider.
	localparam int unsigned DayShift    = 7;
	localparam int unsigned DayDivisor  = 675;
	localparam int unsigned DayRecip    = 25451658;  // floor(2^34 / 675)
	localparam int unsigned DayRecipSh  = 34;

	localparam int unsigned CycleDays   = 1461;
	localparam int unsigned CycleRecip  = 45933;     // floor(2^26 / 1461)
	localparam int unsigned CycleRecipSh = 26;

	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned HourRecip   = 4660;      // floor(2^24 / 3600)
	localparam int unsigned HourRecipSh = 24;

	localparam int unsigned SecsPerMin  = 60;
	localparam int unsigned MinRecip    = 1092;      // floor(2^16 / 60)
	localparam int unsigned MinRecipSh  = 16;

	localparam int unsigned DaysPerYear = 365;
	localparam int unsigned BaseYear    = 2001;
	localparam int unsigned FinalYear   = 2099;
	localparam int unsigned DayLimit    =
		(FinalYear - BaseYear + 1) * DaysPerYear + (FinalYear - BaseYear + 1) / 4;

	typedef logic [8:0] doy_t;

	localparam doy_t MonthStartNormal [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	localparam doy_t MonthStartLeap [12] = '{
		9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
		9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
	};

	function automatic doy_t month_start(input logic leap, input logic [3:0] idx);
		doy_t start;
		start = 9'd0;
		if (idx < 4'd12) begin
			start = leap ? MonthStartLeap[idx] : MonthStartNormal[idx];
		end
		return start;
	endfunction

endpackage

// File: rtl/seconds_to_calendar.sv
`timescale 1ns / 1ps

// Channel  Direction  Transaction contents
// s_*      in         tdata[31:0] seconds_count
// m_*      out        tdata: year, month, day_of_month, hour, minute, second; tuser: out_of_range
//
// Every transaction runs through nine register stages, the last of which is the output register;
// a new transaction can enter every cycle unless back-pressure on m_tready stalls the pipeline.
// The constant divisions are reciprocal multiplications followed by one correction step,
// and every product is registered in the stage that computes it, which sets the depth.
// Reset clears only the stage valid bits.
// Each stage holds while the stage after it is full and stalled, so bubbles are squeezed out.

module seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] seconds_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [11:0] year, [15:12] month, [20:16] day_of_month,
	                               // [25:21] hour, [31:26] minute, [37:32] second, [39:38] zero
	output logic        m_tuser    // [0] out_of_range
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en1, en2, en3, en4, en5, en6, en7, en8, en9;

	assign en9 = !v_s9 || m_tready;
	assign en8 = !v_s8 || en9;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign s_tready = en1;
	assign m_tvalid = v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
			if (en9) v_s9 <= v_s8;
		end
	end

	// Stage 1: reciprocal product for the day count.
	logic [24:0] x_s1;
	logic [6:0]  lo_s1;
	logic [49:0] p1_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1  <= s_tdata[31:s2c_pkg::DayShift];
			lo_s1 <= s_tdata[s2c_pkg::DayShift-1:0];
			p1_s1 <= 50'(s_tdata[31:s2c_pkg::DayShift]) * 50'(s2c_pkg::DayRecip);
		end
	end

	// Stage 2: estimated day count and its back product.
	logic [15:0] q1;
	logic [15:0] q1_s2;
	logic [25:0] t1_s2;
	logic [24:0] x_s2;
	logic [6:0]  lo_s2;

	assign q1 = p1_s1[49:s2c_pkg::DayRecipSh];

	always_ff @(posedge clk) begin
		if (en2) begin
			q1_s2 <= q1;
			t1_s2 <= 26'(q1) * 26'(s2c_pkg::DayDivisor);
			x_s2  <= x_s1;
			lo_s2 <= lo_s1;
		end
	end

	// Stage 3: correct the estimate to give whole days and seconds of the day.
	logic [25:0] r1;
	logic [15:0] days_s3;
	logic [16:0] rem_s3;

	assign r1 = 26'(x_s2) - t1_s2;

	always_ff @(posedge clk) begin
		if (en3) begin
			if (r1 >= 26'(s2c_pkg::DayDivisor)) begin
				days_s3 <= q1_s2 + 16'd1;
				rem_s3  <= {10'(r1 - 26'(s2c_pkg::DayDivisor)), lo_s2};
			end else begin
				days_s3 <= q1_s2;
				rem_s3  <= {r1[9:0], lo_s2};
			end
		end
	end

	// Stage 4: out-of-range flag and reciprocal products for the four-year cycle and the hour.
	logic [15:0] days_s4;
	logic [16:0] rem_s4;
	logic        oor_s4;
	logic [31:0] pc_s4;
	logic [29:0] ph_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			days_s4 <= days_s3;
			rem_s4  <= rem_s3;
			oor_s4  <= days_s3 >= 16'(s2c_pkg::DayLimit);
			pc_s4   <= 32'(days_s3) * 32'(s2c_pkg::CycleRecip);
			ph_s4   <= 30'(rem_s3) * 30'(s2c_pkg::HourRecip);
		end
	end

	// Stage 5: estimates and back products.
	logic [5:0]  qc;
	logic [5:0]  qh;
	logic [5:0]  qc_s5;
	logic [5:0]  qh_s5;
	logic [16:0] tc_s5;
	logic [16:0] th_s5;
	logic [15:0] days_s5;
	logic [16:0] rem_s5;
	logic        oor_s5;

	assign qc = pc_s4[31:s2c_pkg::CycleRecipSh];
	assign qh = ph_s4[29:s2c_pkg::HourRecipSh];

	always_ff @(posedge clk) begin
		if (en5) begin
			qc_s5   <= qc;
			qh_s5   <= qh;
			tc_s5   <= 17'(qc) * 17'(s2c_pkg::CycleDays);
			th_s5   <= 17'(qh) * 17'(s2c_pkg::SecsPerHour);
			days_s5 <= days_s4;
			rem_s5  <= rem_s4;
			oor_s5  <= oor_s4;
		end
	end

	// Stage 6: corrected cycle, day of cycle, hour and seconds of the hour.
	logic [16:0] rc;
	logic [16:0] rh;
	logic [5:0]  cyc_s6;
	logic [10:0] rday_s6;
	logic [4:0]  hour_s6;
	logic [11:0] rs_s6;
	logic        oor_s6;

	assign rc = 17'(days_s5) - tc_s5;
	assign rh = rem_s5 - th_s5;

	always_ff @(posedge clk) begin
		if (en6) begin
			oor_s6 <= oor_s5;
			if (rc >= 17'(s2c_pkg::CycleDays)) begin
				cyc_s6  <= qc_s5 + 6'd1;
				rday_s6 <= 11'(rc - 17'(s2c_pkg::CycleDays));
			end else begin
				cyc_s6  <= qc_s5;
				rday_s6 <= rc[10:0];
			end
			if (rh >= 17'(s2c_pkg::SecsPerHour)) begin
				hour_s6 <= 5'(qh_s5 + 6'd1);
				rs_s6   <= 12'(rh - 17'(s2c_pkg::SecsPerHour));
			end else begin
				hour_s6 <= qh_s5[4:0];
				rs_s6   <= rh[11:0];
			end
		end
	end

	// Stage 7: year inside the cycle, day of year, minute product.
	logic [1:0]  yi;
	logic [10:0] ybase;
	logic [1:0]  yi_s7;
	logic [8:0]  doy_s7;
	logic [5:0]  cyc_s7;
	logic [4:0]  hour_s7;
	logic [11:0] rs_s7;
	logic [22:0] pm_s7;
	logic        oor_s7;

	always_comb begin
		if (rday_s6 >= 11'(3 * s2c_pkg::DaysPerYear)) begin
			yi    = 2'd3;
			ybase = 11'(3 * s2c_pkg::DaysPerYear);
		end else if (rday_s6 >= 11'(2 * s2c_pkg::DaysPerYear)) begin
			yi    = 2'd2;
			ybase = 11'(2 * s2c_pkg::DaysPerYear);
		end else if (rday_s6 >= 11'(s2c_pkg::DaysPerYear)) begin
			yi    = 2'd1;
			ybase = 11'(s2c_pkg::DaysPerYear);
		end else begin
			yi    = 2'd0;
			ybase = 11'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			yi_s7   <= yi;
			doy_s7  <= 9'(rday_s6 - ybase);
			cyc_s7  <= cyc_s6;
			hour_s7 <= hour_s6;
			rs_s7   <= rs_s6;
			pm_s7   <= 23'(rs_s6) * 23'(s2c_pkg::MinRecip);
			oor_s7  <= oor_s6;
		end
	end

	// Stage 8: month from the month start table, year, minute back product.
	logic        leap;
	logic [3:0]  mon;
	logic [5:0]  qm;
	logic [3:0]  mon_s8;
	logic [8:0]  doy_s8;
	logic        leap_s8;
	logic [11:0] year_s8;
	logic [4:0]  hour_s8;
	logic [11:0] rs_s8;
	logic [5:0]  qm_s8;
	logic [11:0] tm_s8;
	logic        oor_s8;

	assign leap = yi_s7 == 2'd3;
	assign qm   = pm_s7[21:s2c_pkg::MinRecipSh];

	always_comb begin
		mon = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s7 >= s2c_pkg::month_start(leap, 4'(k))) begin
				mon = 4'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en8) begin
			mon_s8  <= mon;
			doy_s8  <= doy_s7;
			leap_s8 <= leap;
			year_s8 <= 12'(s2c_pkg::BaseYear) + {4'd0, cyc_s7, 2'd0} + {10'd0, yi_s7};
			hour_s8 <= hour_s7;
			rs_s8   <= rs_s7;
			qm_s8   <= qm;
			tm_s8   <= 12'(qm) * 12'(s2c_pkg::SecsPerMin);
			oor_s8  <= oor_s7;
		end
	end

	// Stage 9: output register.
	logic [11:0] rm;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [4:0]  day_of_month;
	logic [8:0]  dom_full;

	assign rm       = rs_s8 - tm_s8;
	assign dom_full = doy_s8 - s2c_pkg::month_start(leap_s8, mon_s8) + 9'd1;
	assign day_of_month = dom_full[4:0];

	always_comb begin
		if (rm >= 12'(s2c_pkg::SecsPerMin)) begin
			minute = qm_s8 + 6'd1;
			second = 6'(rm - 12'(s2c_pkg::SecsPerMin));
		end else begin
			minute = qm_s8;
			second = rm[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en9) begin
			m_tuser <= oor_s8;
			if (oor_s8) begin
				m_tdata <= '0;
			end else begin
				m_tdata <= {2'd0, second, minute, hour_s8, day_of_month,
					mon_s8 + 4'd1, year_s8};
			end
		end
	end

endmodule
